// File: hdl/audio_echo_saturating_unit_macros.svh
// Assertion macros shared by the echo unit's modules.
// Both macros expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef AUDIO_ECHO_SATURATING_UNIT_MACROS_SVH
`define AUDIO_ECHO_SATURATING_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AES_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define AES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/aes_pkg.sv
// Package for the echo unit: history depth, register indexes, sample limits and the
// control word that passes from the history stage to the arithmetic stages.
// It has no dependencies.
`default_nettype none

package aes_pkg;

    // The history depth must be a power of two so that the ring addresses wrap naturally.
    localparam int HIST_DEPTH = 65536;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);

    localparam int SAMPLE_W = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY = 1'd1;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    // Control for the item held in the first stage.
    typedef struct packed {
        logic valid;
        logic last;
        logic pass;
        logic bypass;
    } aes_s1_t;

endpackage

`default_nettype wire

// File: hdl/aes_history.sv
// Input stage of the echo unit: ring memory of past samples, write pointer, buffer count
// and the first pipeline register. Depends on aes_pkg and the shared assertion macros.
`default_nettype none
`include "audio_echo_saturating_unit_macros.svh"

module aes_history
    import aes_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       sample_valid,
    output logic                            sample_stall,
    input  wire logic signed [SAMPLE_W-1:0] sample_in,
    input  wire logic                       buffer_last,
    input  wire logic [15:0]                delay_samples,
    input  wire logic                       take,
    output aes_s1_t                         s1,
    output logic signed [SAMPLE_W-1:0]      x1,
    output logic signed [SAMPLE_W-1:0]      tap
);

    logic [SAMPLE_W-1:0] hist_mem [HIST_DEPTH];

    logic [HIST_AW-1:0]          wp_reg;
    logic [HIST_AW-1:0]          wp_next;
    logic [15:0]                 seen_reg;
    logic [15:0]                 seen_next;
    aes_s1_t                     s1_reg;
    aes_s1_t                     s1_next;
    logic signed [SAMPLE_W-1:0]  x1_reg;
    logic [SAMPLE_W-1:0]         tap_reg;
    logic [HIST_AW-1:0]          dmod;
    logic [HIST_AW-1:0]          rp;
    logic                        en1;
    logic                        accept;

    assign en1          = !s1_reg.valid || take;
    assign sample_stall = !en1;
    assign accept       = sample_valid && en1;

    // The delay wraps modulo the depth; a delay of zero reads the entry being written.
    assign dmod = HIST_AW'(delay_samples);
    assign rp   = wp_reg - dmod;

    always_comb
    begin
        wp_next   = wp_reg;
        seen_next = seen_reg;
        s1_next   = s1_reg;
        if (accept)
        begin
            wp_next = wp_reg + 1'b1;
            if (buffer_last)
            begin
                seen_next = '0;
            end
            else if (seen_reg < delay_samples)
            begin
                seen_next = seen_reg + 16'd1;
            end
        end
        if (en1)
        begin
            s1_next.valid  = accept;
            s1_next.last   = buffer_last;
            s1_next.pass   = (seen_reg < delay_samples);
            s1_next.bypass = (dmod == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            seen_reg <= '0;
            s1_reg   <= '0;
        end
        else
        begin
            wp_reg   <= wp_next;
            seen_reg <= seen_next;
            s1_reg   <= s1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hist_mem[wp_reg] <= sample_in;
            tap_reg          <= hist_mem[rp];
            x1_reg           <= sample_in;
        end
    end

    assign s1  = s1_reg;
    assign x1  = x1_reg;
    assign tap = $signed(tap_reg);

    `AES_ASSERT_NEXT(a_last_restarts, accept && buffer_last, seen_reg == '0,
        "buffer count not restarted after last item")
    `AES_ASSERT_NEXT(a_accept_lands, accept, s1_reg.valid,
        "accepted item missing from first stage")
    `AES_ASSERT_NEXT(a_s1_holds, s1_reg.valid && !take,
        s1_reg.valid && $stable(x1_reg) && $stable(tap_reg),
        "first stage lost or changed a held item")

endmodule

`default_nettype wire

// File: hdl/aes_mac.sv
// Arithmetic stages of the echo unit: the gain product register, then the truncating
// sum with saturation into the result register. Depends on aes_pkg and the macros.
`default_nettype none
`include "audio_echo_saturating_unit_macros.svh"

module aes_mac
    import aes_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire aes_s1_t                    s1,
    input  wire logic signed [SAMPLE_W-1:0] x1,
    input  wire logic signed [SAMPLE_W-1:0] tap,
    input  wire logic [15:0]                decay_gain,
    output logic                            take,
    output logic                            result_valid,
    input  wire logic                       result_stall,
    output logic signed [SAMPLE_W-1:0]      sample_out,
    output logic                            out_last
);

    logic                        v2_reg;
    logic                        v2_next;
    logic                        last2_reg;
    logic                        pass2_reg;
    logic signed [SAMPLE_W-1:0]  x2_reg;
    logic signed [31:0]          prod2_reg;
    logic                        v3_reg;
    logic                        v3_next;
    logic signed [SAMPLE_W-1:0]  y3_reg;
    logic                        last3_reg;

    logic                        en3;
    logic signed [SAMPLE_W-1:0]  past;
    logic signed [16:0]          gain_s;
    logic signed [32:0]          prod_full;
    logic signed [31:0]          biased;
    logic signed [16:0]          quot;
    logic signed [17:0]          sum;
    logic signed [SAMPLE_W-1:0]  sat;
    logic signed [SAMPLE_W-1:0]  y;

    assign en3  = !v3_reg || !result_stall;
    assign take = !v2_reg || en3;

    // With a zero delay the echo tap is the sample itself.
    assign past      = s1.bypass ? x1 : tap;
    assign gain_s    = $signed({1'b0, decay_gain});
    assign prod_full = past * gain_s;

    // Division by 32768 truncated toward zero: negative products are biased first.
    assign biased = prod2_reg + (prod2_reg[31] ? 32'sd32767 : 32'sd0);
    assign quot   = biased[31:15];
    assign sum    = {{2{x2_reg[SAMPLE_W-1]}}, x2_reg} + {quot[16], quot};

    always_comb
    begin
        if (sum[17:15] == 3'b000 || sum[17:15] == 3'b111)
        begin
            sat = sum[15:0];
        end
        else if (sum[17])
        begin
            sat = SAMPLE_MIN;
        end
        else
        begin
            sat = SAMPLE_MAX;
        end
        y = pass2_reg ? x2_reg : sat;
    end

    assign v2_next = take ? s1.valid : v2_reg;
    assign v3_next = en3 ? v2_reg : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && s1.valid)
        begin
            x2_reg    <= x1;
            last2_reg <= s1.last;
            pass2_reg <= s1.pass;
            prod2_reg <= prod_full[31:0];
        end
        if (en3 && v2_reg)
        begin
            y3_reg    <= y;
            last3_reg <= last2_reg;
        end
    end

    assign result_valid = v3_reg;
    assign sample_out   = y3_reg;
    assign out_last     = last3_reg;

    `AES_ASSERT_NEXT(a_s2_holds, v2_reg && !en3, v2_reg && $stable(prod2_reg),
        "second stage lost or changed a held item")
    `AES_ASSERT_NEXT(a_pass_through, v2_reg && pass2_reg && en3, y3_reg == $past(x2_reg),
        "pass-through item altered")
    `AES_ASSERT_NEXT(a_zero_echo, v2_reg && !pass2_reg && prod2_reg == '0 && en3,
        y3_reg == $past(x2_reg),
        "silent echo altered the sample")

endmodule

`default_nettype wire

// File: hdl/audio_echo_saturating_unit.sv
// Top level of the saturating echo unit: configuration registers and the two stages.
// Depends on aes_pkg, aes_history and aes_mac.
//
// Usage. Samples arrive on the sample channel (sample_valid, sample_stall, sample_in,
// buffer_last); each accepted item yields exactly one item on the result channel
// (result_valid, result_stall, sample_out, out_last), in order. An item moves when its
// valid is high and its stall is low. Within a buffer the first delay_samples items pass
// through; later ones have the sample from delay_samples items earlier, scaled by
// decay_gain (unsigned Q1.15, truncated toward zero), added and saturated to 16 bits.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready;
// index 0 is delay_samples, index 1 is decay_gain. Write it only while the unit is idle.
// An item passes three registers: the first pipeline register, the gain product register
// and the result register, which drives result_valid. Throughput is one item per cycle while
// the receiver does not stall: the history memory takes one write and one registered read
// per accepted item through its own write and read ports, and every stage moves each cycle.
// Reset clears the pointer, the buffer count, both registers and all valid flags; the
// history memory is not cleared. When the receiver stalls, the result register holds and
// the earlier stages keep filling, so up to three items are held before sample_stall rises.
`default_nettype none

module audio_echo_saturating_unit
    import aes_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       sample_valid,
    output logic                            sample_stall,
    input  wire logic signed [SAMPLE_W-1:0] sample_in,
    input  wire logic                       buffer_last,
    output logic                            result_valid,
    input  wire logic                       result_stall,
    output logic signed [SAMPLE_W-1:0]      sample_out,
    output logic                            out_last,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [15:0]                cfg_data
);

    logic [15:0]                delay_reg;
    logic [15:0]                delay_next;
    logic [15:0]                decay_reg;
    logic [15:0]                decay_next;
    aes_s1_t                    s1;
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W-1:0] tap;
    logic                       take;

    // Registers are always writable; the index picks which one.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        delay_next = delay_reg;
        decay_next = decay_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DELAY: delay_next = cfg_data;
                REG_DECAY: decay_next = cfg_data;
                default:   delay_next = delay_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= '0;
            decay_reg <= '0;
        end
        else
        begin
            delay_reg <= delay_next;
            decay_reg <= decay_next;
        end
    end

    // History memory, write pointer, buffer count and the first pipeline register.
    aes_history u_history (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .sample_in     (sample_in),
        .buffer_last   (buffer_last),
        .delay_samples (delay_reg),
        .take          (take),
        .s1            (s1),
        .x1            (x1),
        .tap           (tap)
    );

    // Gain product, then truncating sum with saturation into the result register.
    aes_mac u_mac (
        .clk          (clk),
        .rst_n        (rst_n),
        .s1           (s1),
        .x1           (x1),
        .tap          (tap),
        .decay_gain   (decay_reg),
        .take         (take),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sample_out   (sample_out),
        .out_last     (out_last)
    );

endmodule

`default_nettype wire
